### rtl/core/mips_integer_core_step_defines.svh
// assertion macros for the mips core step block
// no dependencies
`ifndef MIPS_INTEGER_CORE_STEP_DEFINES_SVH
`define MIPS_INTEGER_CORE_STEP_DEFINES_SVH
// property that must hold every clock outside reset
`define MCS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// assertion checked also during reset
`define MCS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

### rtl/core/mcs_pkg.sv
// types and constants for the mips core step block
// no dependencies
package mcs_pkg;
  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_READ, ST_EXEC, ST_MUL, ST_DIV, ST_DFIX,
    ST_MEM_RD, ST_MEM_WAIT, ST_MEM_WR, ST_DONE
  } state_t;

  // instruction classes seen by the controller
  typedef enum logic [2:0] {
    CL_SIMPLE, CL_MUL, CL_DIV, CL_LOAD, CL_STORE, CL_ILLEGAL
  } iclass_t;

  // opcodes
  localparam logic [5:0] OP_SPECIAL = 6'd0;
  localparam logic [5:0] OP_REGIMM  = 6'd1;
  localparam logic [5:0] OP_J       = 6'd2;
  localparam logic [5:0] OP_JAL     = 6'd3;
  localparam logic [5:0] OP_BEQ     = 6'd4;
  localparam logic [5:0] OP_BNE     = 6'd5;
  localparam logic [5:0] OP_BLEZ    = 6'd6;
  localparam logic [5:0] OP_BGTZ    = 6'd7;
  localparam logic [5:0] OP_ADDI    = 6'd8;
  localparam logic [5:0] OP_ADDIU   = 6'd9;
  localparam logic [5:0] OP_SLTI    = 6'd10;
  localparam logic [5:0] OP_SLTIU   = 6'd11;
  localparam logic [5:0] OP_ANDI    = 6'd12;
  localparam logic [5:0] OP_ORI     = 6'd13;
  localparam logic [5:0] OP_XORI    = 6'd14;
  localparam logic [5:0] OP_LUI     = 6'd15;
  localparam logic [5:0] OP_LB      = 6'd32;
  localparam logic [5:0] OP_LH      = 6'd33;
  localparam logic [5:0] OP_LW      = 6'd35;
  localparam logic [5:0] OP_LBU     = 6'd36;
  localparam logic [5:0] OP_LHU     = 6'd37;
  localparam logic [5:0] OP_SB      = 6'd40;
  localparam logic [5:0] OP_SH      = 6'd41;
  localparam logic [5:0] OP_SW      = 6'd43;

  // special function codes
  localparam logic [5:0] FN_SLL     = 6'd0;
  localparam logic [5:0] FN_SRL     = 6'd2;
  localparam logic [5:0] FN_SRA     = 6'd3;
  localparam logic [5:0] FN_SLLV    = 6'd4;
  localparam logic [5:0] FN_SRLV    = 6'd6;
  localparam logic [5:0] FN_SRAV    = 6'd7;
  localparam logic [5:0] FN_JR      = 6'd8;
  localparam logic [5:0] FN_JALR    = 6'd9;
  localparam logic [5:0] FN_SYSCALL = 6'd12;
  localparam logic [5:0] FN_MFHI    = 6'd16;
  localparam logic [5:0] FN_MTHI    = 6'd17;
  localparam logic [5:0] FN_MFLO    = 6'd18;
  localparam logic [5:0] FN_MTLO    = 6'd19;
  localparam logic [5:0] FN_MULT    = 6'd24;
  localparam logic [5:0] FN_MULTU   = 6'd25;
  localparam logic [5:0] FN_DIV     = 6'd26;
  localparam logic [5:0] FN_DIVU    = 6'd27;
  localparam logic [5:0] FN_ADD     = 6'd32;
  localparam logic [5:0] FN_ADDU    = 6'd33;
  localparam logic [5:0] FN_SUB     = 6'd34;
  localparam logic [5:0] FN_SUBU    = 6'd35;
  localparam logic [5:0] FN_AND     = 6'd36;
  localparam logic [5:0] FN_OR      = 6'd37;
  localparam logic [5:0] FN_XOR     = 6'd38;
  localparam logic [5:0] FN_NOR     = 6'd39;
  localparam logic [5:0] FN_SLT     = 6'd42;
  localparam logic [5:0] FN_SLTU    = 6'd43;

  localparam logic [4:0]  LINK_REG     = 5'd31;
  localparam logic [31:0] HALT_CODE    = 32'd10;
  localparam logic [31:0] PC_TOP_MASK  = 32'hf000_0000;
  localparam int          DIV_STEPS    = 32;

  // controller to datapath
  typedef struct packed {
    logic latch_ir;
    logic rf_read;
    logic exec;
    logic mul_step;
    logic div_start;
    logic div_step;
    logic div_fix;
    logic mem_rd;
    logic mem_wr;
    logic mem_load_byte;
    logic clr_wr;
    logic commit;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    iclass_t iclass;
    logic    last_byte;
    logic    div_last;
    logic    clr_last;
  } dp_sts_t;
endpackage

### rtl/core/mcs_ctrl.sv
// controller state machine of the mips core step block
// depends on mcs_pkg
module mcs_ctrl import mcs_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  output logic    cfg_ready,
  output dp_cmd_t cmd,
  input  dp_sts_t sts
);
  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_CLEAR;
    else state_r <= state_nxt;
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    cfg_ready = (state_r == ST_IDLE) || (state_r == ST_CLEAR);
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.latch_ir = 1'b1;
          state_nxt    = ST_READ;
        end
      end
      ST_READ: begin
        cmd.rf_read = 1'b1;
        state_nxt   = ST_EXEC;
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        unique case (sts.iclass)
          CL_MUL:   state_nxt = ST_MUL;
          CL_DIV:   begin cmd.div_start = 1'b1; state_nxt = ST_DIV; end
          CL_LOAD:  state_nxt = ST_MEM_RD;
          CL_STORE: state_nxt = ST_MEM_RD;
          default:  state_nxt = ST_DONE;
        endcase
      end
      ST_MUL: begin
        cmd.mul_step = 1'b1;
        state_nxt    = ST_DONE;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = ST_DFIX;
      end
      ST_DFIX: begin
        cmd.div_fix = 1'b1;
        state_nxt   = ST_DONE;
      end
      ST_MEM_RD: begin
        cmd.mem_rd = 1'b1;
        state_nxt  = ST_MEM_WAIT;
      end
      ST_MEM_WAIT: begin
        if (sts.iclass == CL_STORE) begin
          state_nxt = ST_MEM_WR;
        end else begin
          cmd.mem_load_byte = 1'b1;
          state_nxt = sts.last_byte ? ST_DONE : ST_MEM_RD;
        end
      end
      ST_MEM_WR: begin
        cmd.mem_wr = 1'b1;
        state_nxt  = sts.last_byte ? ST_DONE : ST_MEM_RD;
      end
      ST_DONE: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule

### rtl/core/mcs_datapath.sv
// datapath of the mips core step block: registers, alu, mul, div, memory
// depends on mcs_pkg
module mcs_datapath import mcs_pkg::*; #(
  parameter int DATA_WORDS = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [31:0] in_instruction_word,
  input  logic        cfg_write,
  input  logic [31:0] cfg_start_address,
  input  dp_cmd_t     cmd,
  output dp_sts_t     sts,
  output logic [31:0] next_pc,
  output logic        reg_write_enable,
  output logic [4:0]  reg_write_index,
  output logic [31:0] reg_write_value,
  output logic [31:0] hi_value,
  output logic [31:0] lo_value,
  output logic        halt,
  output logic        syscall_seen,
  output logic [31:0] syscall_code,
  output logic [31:0] syscall_argument,
  output logic        illegal
);
  localparam int AW = $clog2(DATA_WORDS);

  logic [31:0] ir_r;
  logic [31:0] pc_r, hi_r, lo_r;
  logic [31:0] a_r, b_r, r2_r, r4_r;
  logic [31:0] rf [32];
  logic [31:0] mem [DATA_WORDS];

  // result registers
  logic [31:0] npc_r, wv_r, hi_nxt_r, lo_nxt_r;
  logic        we_r, halt_r, seen_r, ill_r;
  logic [4:0]  wi_r;
  iclass_t     cls_r;

  // multiply / divide working registers
  logic        mul_signed_r;
  logic [31:0] dq_r, drem_r, ddiv_r;
  logic [5:0]  dcnt_r;
  logic        dneg_q_r, dneg_r_r, dzero_r, dovf_r;
  logic [31:0] dsrc_a_r;

  // memory access registers
  logic [31:0] addr_r, ldata_r, mword_r;
  logic [1:0]  bidx_r, nbytes_r;
  logic        rf_clear_r;
  logic [AW:0] clr_cnt_r;

  // instruction fields
  logic [5:0]  op, fn;
  logic [4:0]  rs, rt, rd, sh;
  logic [15:0] imm;
  logic [31:0] simm, brt, pc4;
  assign op   = ir_r[31:26];
  assign fn   = ir_r[5:0];
  assign rs   = ir_r[25:21];
  assign rt   = ir_r[20:16];
  assign rd   = ir_r[15:11];
  assign sh   = ir_r[10:6];
  assign imm  = ir_r[15:0];
  assign simm = {{16{imm[15]}}, imm};
  assign brt  = pc_r + {simm[29:0], 2'b00};
  assign pc4  = pc_r + 32'd4;

  // instruction register
  always_ff @(posedge clk) begin
    if (cmd.latch_ir) ir_r <= in_instruction_word;
  end

  // register file read
  always_ff @(posedge clk) begin
    if (cmd.rf_read) begin
      a_r  <= rf[rs];
      b_r  <= rf[rt];
      r2_r <= rf[2];
      r4_r <= rf[4];
    end
  end

  // decode and combinational execute
  logic [31:0] e_npc, e_wv, e_hi, e_lo;
  logic        e_we, e_halt, e_seen;
  logic [4:0]  e_wi;
  iclass_t     e_cls;
  logic [4:0]  vsh;
  assign vsh = a_r[4:0];

  always_comb begin
    e_npc = pc4; e_wv = '0; e_wi = '0; e_we = 1'b0;
    e_hi = hi_r; e_lo = lo_r; e_halt = 1'b0; e_seen = 1'b0;
    e_cls = CL_SIMPLE;
    unique case (op)
      OP_SPECIAL: begin
        unique case (fn)
          FN_SLL:  begin e_we = 1'b1; e_wi = rd; e_wv = b_r << sh; end
          FN_SRL:  begin e_we = 1'b1; e_wi = rd; e_wv = b_r >> sh; end
          FN_SRA:  begin e_we = 1'b1; e_wi = rd; e_wv = $signed(b_r) >>> sh; end
          FN_SLLV: begin e_we = 1'b1; e_wi = rd; e_wv = b_r << vsh; end
          FN_SRLV: begin e_we = 1'b1; e_wi = rd; e_wv = b_r >> vsh; end
          FN_SRAV: begin e_we = 1'b1; e_wi = rd; e_wv = $signed(b_r) >>> vsh; end
          FN_JR:   e_npc = a_r;
          FN_JALR: begin e_npc = a_r; e_we = 1'b1; e_wi = LINK_REG; e_wv = pc4; end
          FN_SYSCALL: begin
            if (r2_r == HALT_CODE) e_halt = 1'b1;
            else e_seen = 1'b1;
          end
          FN_MFHI: begin e_we = 1'b1; e_wi = rd; e_wv = hi_r; end
          FN_MTHI: e_hi = a_r;
          FN_MFLO: begin e_we = 1'b1; e_wi = rd; e_wv = lo_r; end
          FN_MTLO: e_lo = a_r;
          FN_MULT, FN_MULTU: e_cls = CL_MUL;
          FN_DIV, FN_DIVU:   e_cls = CL_DIV;
          FN_ADD, FN_ADDU: begin e_we = 1'b1; e_wi = rd; e_wv = a_r + b_r; end
          FN_SUB, FN_SUBU: begin e_we = 1'b1; e_wi = rd; e_wv = a_r - b_r; end
          FN_AND:  begin e_we = 1'b1; e_wi = rd; e_wv = a_r & b_r; end
          FN_OR:   begin e_we = 1'b1; e_wi = rd; e_wv = a_r | b_r; end
          FN_XOR:  begin e_we = 1'b1; e_wi = rd; e_wv = a_r ^ b_r; end
          FN_NOR:  begin e_we = 1'b1; e_wi = rd; e_wv = ~(a_r | b_r); end
          FN_SLT:  begin
            e_we = 1'b1; e_wi = rd; e_wv = {31'd0, $signed(a_r) < $signed(b_r)};
          end
          FN_SLTU: begin e_we = 1'b1; e_wi = rd; e_wv = {31'd0, a_r < b_r}; end
          default: e_cls = CL_ILLEGAL;
        endcase
      end
      OP_REGIMM: begin
        if (rt == 5'd0) begin
          if (a_r[31]) e_npc = brt;
        end else if (rt == 5'd1) begin
          if (!a_r[31]) e_npc = brt;
        end else begin
          e_cls = CL_ILLEGAL;
        end
      end
      OP_J:   e_npc = {pc4[31:28], ir_r[25:0], 2'b00};
      OP_JAL: begin
        e_npc = {pc4[31:28], ir_r[25:0], 2'b00};
        e_we = 1'b1; e_wi = LINK_REG; e_wv = pc4;
      end
      OP_BEQ:  if (a_r == b_r) e_npc = brt;
      OP_BNE:  if (a_r != b_r) e_npc = brt;
      OP_BLEZ: if (a_r[31] || a_r == 32'd0) e_npc = brt;
      OP_BGTZ: if (!a_r[31] && a_r != 32'd0) e_npc = brt;
      OP_ADDI, OP_ADDIU: begin e_we = 1'b1; e_wi = rt; e_wv = a_r + simm; end
      OP_SLTI: begin
        e_we = 1'b1; e_wi = rt; e_wv = {31'd0, $signed(a_r) < $signed(simm)};
      end
      OP_SLTIU: begin e_we = 1'b1; e_wi = rt; e_wv = {31'd0, a_r < simm}; end
      OP_ANDI: begin e_we = 1'b1; e_wi = rt; e_wv = a_r & {16'd0, imm}; end
      OP_ORI:  begin e_we = 1'b1; e_wi = rt; e_wv = a_r | {16'd0, imm}; end
      OP_XORI: begin e_we = 1'b1; e_wi = rt; e_wv = a_r ^ {16'd0, imm}; end
      OP_LUI:  begin e_we = 1'b1; e_wi = rt; e_wv = {imm, 16'd0}; end
      OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU: begin
        e_cls = CL_LOAD; e_we = 1'b1; e_wi = rt;
      end
      OP_SB, OP_SH, OP_SW: e_cls = CL_STORE;
      default: e_cls = CL_ILLEGAL;
    endcase
  end

  // byte count of a memory access, minus one
  logic [1:0] e_nb;
  always_comb begin
    unique case (op)
      OP_LH, OP_LHU, OP_SH: e_nb = 2'd1;
      OP_LW, OP_SW:         e_nb = 2'd3;
      default:              e_nb = 2'd0;
    endcase
  end

  // class of the instruction held in the instruction register
  assign sts.iclass    = e_cls;
  assign sts.last_byte = (bidx_r == nbytes_r);
  assign sts.div_last  = (dcnt_r == 6'(DIV_STEPS - 1));
  assign sts.clr_last  = (clr_cnt_r == (AW + 1)'(DATA_WORDS - 1));

  // multiplier: one 33x33 signed product
  logic [32:0] ma, mb;
  logic [63:0] prod;
  assign ma   = {mul_signed_r & a_r[31], a_r};
  assign mb   = {mul_signed_r & b_r[31], b_r};
  assign prod = 64'($signed(ma) * $signed(mb));

  // restoring divider on magnitudes, one bit per cycle
  logic [32:0] dtrial;
  logic [31:0] drem_sh;
  assign drem_sh = {drem_r[30:0], dq_r[31]};
  assign dtrial  = {drem_r, dq_r[31]} - {1'b0, ddiv_r};

  logic        sgn_div;
  assign sgn_div = (fn == FN_DIV);

  // memory byte lane
  logic [AW-1:0] waddr;
  logic [1:0]    lane;
  logic [31:0]   cur_addr;
  logic [7:0]    rd_byte, st_byte;
  assign cur_addr = addr_r + {30'd0, bidx_r};
  assign waddr    = cur_addr[AW+1:2];
  assign lane     = cur_addr[1:0];
  assign rd_byte  = mword_r[{lane, 3'b000} +: 8];
  assign st_byte  = b_r[{bidx_r, 3'b000} +: 8];

  // memory: clearing pass after reset, then byte read-modify-write
  always_ff @(posedge clk) begin
    if (cmd.clr_wr) begin
      mem[clr_cnt_r[AW-1:0]] <= '0;
    end else if (cmd.mem_wr) begin
      mem[waddr] <= (mword_r & ~(32'hff << {lane, 3'b000}))
                  | ({24'd0, st_byte} << {lane, 3'b000});
    end
    if (cmd.mem_rd) mword_r <= mem[waddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) clr_cnt_r <= '0;
    else if (cmd.clr_wr) clr_cnt_r <= clr_cnt_r + 1'b1;
  end

  // load assembly and final load value
  logic [31:0] ld_final;
  always_comb begin
    unique case (op)
      OP_LB:   ld_final = {{24{ldata_r[7]}}, ldata_r[7:0]};
      OP_LH:   ld_final = {{16{ldata_r[15]}}, ldata_r[15:0]};
      OP_LBU:  ld_final = {24'd0, ldata_r[7:0]};
      OP_LHU:  ld_final = {16'd0, ldata_r[15:0]};
      default: ld_final = ldata_r;
    endcase
  end

  // work registers per command
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      npc_r <= e_npc; wv_r <= e_wv; wi_r <= e_wi; we_r <= e_we;
      hi_nxt_r <= e_hi; lo_nxt_r <= e_lo; halt_r <= e_halt; seen_r <= e_seen;
      ill_r <= (e_cls == CL_ILLEGAL);
      cls_r <= e_cls;
      mul_signed_r <= (fn == FN_MULT);
      addr_r <= a_r + simm;
      bidx_r <= '0;
      nbytes_r <= e_nb;
      ldata_r <= '0;
    end
    if (cmd.mul_step) begin
      hi_nxt_r <= prod[63:32];
      lo_nxt_r <= prod[31:0];
    end
    if (cmd.div_start) begin
      dsrc_a_r <= a_r;
      dzero_r  <= (b_r == 32'd0);
      dovf_r   <= sgn_div && a_r == 32'h8000_0000 && b_r == 32'hffff_ffff;
      dneg_q_r <= sgn_div && (a_r[31] ^ b_r[31]);
      dneg_r_r <= sgn_div && a_r[31];
      dq_r     <= (sgn_div && a_r[31]) ? -a_r : a_r;
      ddiv_r   <= (sgn_div && b_r[31]) ? -b_r : b_r;
      drem_r   <= '0;
      dcnt_r   <= '0;
    end
    if (cmd.div_step) begin
      dcnt_r <= dcnt_r + 6'd1;
      if (!dtrial[32]) begin
        drem_r <= dtrial[31:0];
        dq_r   <= {dq_r[30:0], 1'b1};
      end else begin
        drem_r <= drem_sh;
        dq_r   <= {dq_r[30:0], 1'b0};
      end
    end
    if (cmd.div_fix) begin
      if (dzero_r) begin
        lo_nxt_r <= 32'hffff_ffff; hi_nxt_r <= dsrc_a_r;
      end else if (dovf_r) begin
        lo_nxt_r <= 32'h8000_0000; hi_nxt_r <= '0;
      end else begin
        lo_nxt_r <= dneg_q_r ? -dq_r : dq_r;
        hi_nxt_r <= dneg_r_r ? -drem_r : drem_r;
      end
    end
    if (cmd.mem_load_byte) begin
      ldata_r[{bidx_r, 3'b000} +: 8] <= rd_byte;
      if (!sts.last_byte) bidx_r <= bidx_r + 2'd1;
    end
    if (cmd.mem_wr && !sts.last_byte) bidx_r <= bidx_r + 2'd1;
    if (cmd.commit && cls_r == CL_LOAD) wv_r <= wv_r;
  end

  // architectural state update at commit
  logic        f_we;
  logic [31:0] f_wv;
  assign f_we = we_r && (wi_r != 5'd0) && !ill_r;
  assign f_wv = (cls_r == CL_LOAD) ? ld_final : wv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= '0; hi_r <= '0; lo_r <= '0; rf_clear_r <= 1'b1;
    end else if (cfg_write) begin
      pc_r <= cfg_start_address;
    end else if (cmd.commit && !ill_r) begin
      pc_r <= npc_r; hi_r <= hi_nxt_r; lo_r <= lo_nxt_r;
    end
    if (rst_n && cmd.clr_wr) rf_clear_r <= 1'b0;
  end

  // register file: cleared during the memory clearing pass
  always_ff @(posedge clk) begin
    for (int i = 0; i < 32; i++) begin
      if (rf_clear_r) rf[i] <= '0;
    end
    if (!rf_clear_r && cmd.commit && f_we) rf[wi_r] <= f_wv;
  end

  // result fields
  assign next_pc          = ill_r ? pc_r : npc_r;
  assign reg_write_enable = f_we;
  assign reg_write_index  = f_we ? wi_r : 5'd0;
  assign reg_write_value  = f_we ? f_wv : 32'd0;
  assign hi_value         = ill_r ? hi_r : hi_nxt_r;
  assign lo_value         = ill_r ? lo_r : lo_nxt_r;
  assign halt             = halt_r && !ill_r;
  assign syscall_seen     = seen_r && !ill_r;
  assign syscall_code     = (halt_r || seen_r) && !ill_r ? r2_r : 32'd0;
  assign syscall_argument = (halt_r || seen_r) && !ill_r ? r4_r : 32'd0;
  assign illegal          = ill_r;
endmodule

### rtl/core/mips_integer_core_step.sv
// mips core step: one instruction word per item, one result item each.
// each item passes the read and execute states; mult adds a multiply step, div
// a divider loop and a fix step, loads and stores a byte-serial memory port pass.
// items are taken one at a time; the divider loop and memory port set the rate.
// reset: synchronous; after reset a clearing pass zeroes
// the data memory and register file before the first item is taken.
module mips_integer_core_step import mcs_pkg::*; #(
  parameter int DATA_WORDS = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_instruction_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_next_pc,
  output logic        out_reg_write_enable,
  output logic [4:0]  out_reg_write_index,
  output logic [31:0] out_reg_write_value,
  output logic [31:0] out_hi_value,
  output logic [31:0] out_lo_value,
  output logic        out_halt,
  output logic        out_syscall_seen,
  output logic [31:0] out_syscall_code,
  output logic [31:0] out_syscall_argument,
  output logic        out_illegal,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_start_address
);
  `include "mips_integer_core_step_defines.svh"

  dp_cmd_t cmd;
  dp_sts_t sts;

  mcs_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .cfg_ready,
    .cmd, .sts
  );

  mcs_datapath #(.DATA_WORDS(DATA_WORDS)) u_dp (
    .clk, .rst_n, .in_instruction_word,
    .cfg_write(cfg_valid && cfg_ready), .cfg_start_address,
    .cmd, .sts,
    .next_pc(out_next_pc), .reg_write_enable(out_reg_write_enable),
    .reg_write_index(out_reg_write_index), .reg_write_value(out_reg_write_value),
    .hi_value(out_hi_value), .lo_value(out_lo_value), .halt(out_halt),
    .syscall_seen(out_syscall_seen), .syscall_code(out_syscall_code),
    .syscall_argument(out_syscall_argument), .illegal(out_illegal)
  );

  // checks
  `MCS_ASSERT(a_no_accept_busy, out_valid |-> in_stall, "item accepted while result pending")
  `MCS_ASSERT(a_ill_clean, (out_valid && out_illegal) |-> !out_reg_write_enable, "illegal wrote")
  `MCS_ASSERT(a_zero_reg, out_reg_write_enable |-> (out_reg_write_index != 5'd0), "reg zero written")
endmodule

### tb/mips_integer_core_step_checker.sv
// checker for the mips core step block: predicts each result item and compares
// depends on mcs_pkg for opcode and function codes
module mips_integer_core_step_checker import mcs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [31:0] in_instruction_word,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] out_next_pc,
  input  logic        out_reg_write_enable,
  input  logic [4:0]  out_reg_write_index,
  input  logic [31:0] out_reg_write_value,
  input  logic [31:0] out_hi_value,
  input  logic [31:0] out_lo_value,
  input  logic        out_halt,
  input  logic        out_syscall_seen,
  input  logic [31:0] out_syscall_code,
  input  logic [31:0] out_syscall_argument,
  input  logic        out_illegal,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [31:0] cfg_start_address,
  output int          fail_count,
  output int          pending,
  output int          checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MEM_WORDS = 4096;

  typedef struct {
    logic [31:0] next_pc;
    logic        we;
    logic [4:0]  wi;
    logic [31:0] wv;
    logic [31:0] hi;
    logic [31:0] lo;
    logic        halt;
    logic        seen;
    logic [31:0] sc;
    logic [31:0] sa;
    logic        ill;
  } step_result_t;

  // shadow architectural state
  logic [31:0] gpr [32];
  logic [31:0] pc, hi_r, lo_r;
  logic [31:0] dmem [MEM_WORDS];
  step_result_t expected_results [$];

  assign pending = expected_results.size();

  function automatic logic [31:0] sx16(logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] mem_load(logic [31:0] a, int n);
    logic [31:0] r;
    logic [31:0] ba;
    r = 0;
    for (int k = 0; k < n; k++) begin
      ba = a + k;
      r |= ((dmem[ba[13:2]] >> (ba[1:0] * 8)) & 32'hff) << (8 * k);
    end
    return r;
  endfunction

  task automatic mem_store(logic [31:0] a, logic [31:0] v, int n);
    logic [31:0] ba;
    for (int k = 0; k < n; k++) begin
      ba = a + k;
      dmem[ba[13:2]][ba[1:0]*8 +: 8] = v[8*k +: 8];
    end
  endtask

  // execute one instruction on the shadow state and queue its result item
  task automatic predict_step(logic [31:0] iw);
    logic [5:0] op, fn;
    logic [4:0] rs, rt, rd, sh;
    logic [15:0] imm;
    logic [31:0] a, b, pc4, npc, wv, hi, lo, sc, sa, addr, brt, simm;
    logic [4:0] wi;
    logic we, halt, seen, ill;
    logic [63:0] p;
    step_result_t r;
    op = iw[31:26]; fn = iw[5:0];
    rs = iw[25:21]; rt = iw[20:16]; rd = iw[15:11]; sh = iw[10:6]; imm = iw[15:0];
    a = gpr[rs]; b = gpr[rt];
    pc4 = pc + 4; npc = pc4; wv = 0; wi = 0;
    simm = sx16(imm); addr = a + simm;
    hi = hi_r; lo = lo_r; sc = 0; sa = 0;
    brt = pc + (simm << 2);
    we = 0; halt = 0; seen = 0; ill = 0;
    case (op)
      OP_SPECIAL: begin
        case (fn)
          FN_SLL:  begin we = 1; wi = rd; wv = b << sh; end
          FN_SRL:  begin we = 1; wi = rd; wv = b >> sh; end
          FN_SRA:  begin we = 1; wi = rd; wv = $signed(b) >>> sh; end
          FN_SLLV: begin we = 1; wi = rd; wv = b << a[4:0]; end
          FN_SRLV: begin we = 1; wi = rd; wv = b >> a[4:0]; end
          FN_SRAV: begin we = 1; wi = rd; wv = $signed(b) >>> a[4:0]; end
          FN_JR:   npc = a;
          FN_JALR: begin npc = a; we = 1; wi = LINK_REG; wv = pc4; end
          FN_SYSCALL: begin
            sc = gpr[2]; sa = gpr[4];
            if (sc == HALT_CODE) halt = 1; else seen = 1;
          end
          FN_MFHI: begin we = 1; wi = rd; wv = hi_r; end
          FN_MTHI: hi = a;
          FN_MFLO: begin we = 1; wi = rd; wv = lo_r; end
          FN_MTLO: lo = a;
          FN_MULT: begin
            p = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
            hi = p[63:32]; lo = p[31:0];
          end
          FN_MULTU: begin
            p = {32'b0, a} * {32'b0, b};
            hi = p[63:32]; lo = p[31:0];
          end
          FN_DIV: begin
            if (b == 0) begin lo = '1; hi = a; end
            else if (a == 32'h8000_0000 && b == '1) begin lo = 32'h8000_0000; hi = 0; end
            else begin lo = $signed(a) / $signed(b); hi = $signed(a) % $signed(b); end
          end
          FN_DIVU: begin
            if (b == 0) begin lo = '1; hi = a; end
            else begin lo = a / b; hi = a % b; end
          end
          FN_ADD, FN_ADDU: begin we = 1; wi = rd; wv = a + b; end
          FN_SUB, FN_SUBU: begin we = 1; wi = rd; wv = a - b; end
          FN_AND:  begin we = 1; wi = rd; wv = a & b; end
          FN_OR:   begin we = 1; wi = rd; wv = a | b; end
          FN_XOR:  begin we = 1; wi = rd; wv = a ^ b; end
          FN_NOR:  begin we = 1; wi = rd; wv = ~(a | b); end
          FN_SLT:  begin we = 1; wi = rd; wv = ($signed(a) < $signed(b)) ? 1 : 0; end
          FN_SLTU: begin we = 1; wi = rd; wv = (a < b) ? 1 : 0; end
          default: ill = 1;
        endcase
      end
      OP_REGIMM: begin
        if (rt == 0) begin if (a[31]) npc = brt; end
        else if (rt == 1) begin if (!a[31]) npc = brt; end
        else ill = 1;
      end
      OP_J:    npc = {iw[25:0], 2'b00} | (pc4 & PC_TOP_MASK);
      OP_JAL:  begin
        npc = {iw[25:0], 2'b00} | (pc4 & PC_TOP_MASK);
        we = 1; wi = LINK_REG; wv = pc4;
      end
      OP_BEQ:  if (a == b) npc = brt;
      OP_BNE:  if (a != b) npc = brt;
      OP_BLEZ: if ($signed(a) <= 0) npc = brt;
      OP_BGTZ: if ($signed(a) > 0) npc = brt;
      OP_ADDI, OP_ADDIU: begin we = 1; wi = rt; wv = a + simm; end
      OP_SLTI:  begin we = 1; wi = rt; wv = ($signed(a) < $signed(simm)) ? 1 : 0; end
      OP_SLTIU: begin we = 1; wi = rt; wv = (a < simm) ? 1 : 0; end
      OP_ANDI:  begin we = 1; wi = rt; wv = a & {16'b0, imm}; end
      OP_ORI:   begin we = 1; wi = rt; wv = a | {16'b0, imm}; end
      OP_XORI:  begin we = 1; wi = rt; wv = a ^ {16'b0, imm}; end
      OP_LUI:   begin we = 1; wi = rt; wv = {imm, 16'b0}; end
      OP_LB:  begin we = 1; wi = rt; wv = mem_load(addr, 1); wv = {{24{wv[7]}}, wv[7:0]}; end
      OP_LH:  begin we = 1; wi = rt; wv = sx16(mem_load(addr, 2)); end
      OP_LW:  begin we = 1; wi = rt; wv = mem_load(addr, 4); end
      OP_LBU: begin we = 1; wi = rt; wv = mem_load(addr, 1); end
      OP_LHU: begin we = 1; wi = rt; wv = mem_load(addr, 2); end
      OP_SB:  mem_store(addr, b, 1);
      OP_SH:  mem_store(addr, b, 2);
      OP_SW:  mem_store(addr, b, 4);
      default: ill = 1;
    endcase

    r = '{default: 0};
    if (ill) begin
      // nothing changes, the pc stays put
      r.next_pc = pc; r.hi = hi_r; r.lo = lo_r; r.ill = 1;
    end else begin
      // register zero stays zero and reports no write
      if (we && wi == 0) begin we = 0; wv = 0; end
      if (we) gpr[wi] = wv;
      hi_r = hi; lo_r = lo; pc = npc;
      r.next_pc = npc; r.we = we; r.wi = we ? wi : 5'd0; r.wv = we ? wv : 32'd0;
      r.hi = hi; r.lo = lo; r.halt = halt; r.seen = seen; r.sc = sc; r.sa = sa;
    end
    expected_results.push_back(r);
  endtask

  function automatic int field_ok(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: mismatch on %s: expected %h, actual %h", $realtime, name, exp_v, act_v);
      return 0;
    end
    return 1;
  endfunction

  // watch the three channels
  always @(posedge clk) begin
    step_result_t e;
    int ok;
    if (!rst_n) begin
      for (int i = 0; i < 32; i++) gpr[i] = 0;
      for (int i = 0; i < MEM_WORDS; i++) dmem[i] = 0;
      pc = 0; hi_r = 0; lo_r = 0;
      expected_results.delete();
      fail_count = 0;
      checked = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result item with no expectation, next_pc %h", $realtime, out_next_pc);
          fail_count++;
        end else begin
          e = expected_results.pop_front();
          ok = 1;
          ok &= field_ok("next_pc", e.next_pc, out_next_pc);
          ok &= field_ok("reg_write_enable", e.we, out_reg_write_enable);
          ok &= field_ok("reg_write_index", e.wi, out_reg_write_index);
          ok &= field_ok("reg_write_value", e.wv, out_reg_write_value);
          ok &= field_ok("hi_value", e.hi, out_hi_value);
          ok &= field_ok("lo_value", e.lo, out_lo_value);
          ok &= field_ok("halt", e.halt, out_halt);
          ok &= field_ok("syscall_seen", e.seen, out_syscall_seen);
          ok &= field_ok("syscall_code", e.sc, out_syscall_code);
          ok &= field_ok("syscall_argument", e.sa, out_syscall_argument);
          ok &= field_ok("illegal", e.ill, out_illegal);
          if (!ok) fail_count++;
          checked++;
        end
      end
      if (cfg_valid && cfg_ready) pc = cfg_start_address;
      if (in_valid && !in_stall) predict_step(in_instruction_word);
    end
  end
endmodule

### tb/tb.sv
// testbench top for the mips core step block: clock, reset, stimulus, verdict
// depends on mcs_pkg, the block and mips_integer_core_step_checker
module tb import mcs_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASE_ITEMS = 440;
  localparam logic [5:0] FN_LIST [27] = '{
    FN_SLL, FN_SRL, FN_SRA, FN_SLLV, FN_SRLV, FN_SRAV, FN_JR, FN_JALR, FN_SYSCALL,
    FN_MFHI, FN_MTHI, FN_MFLO, FN_MTLO, FN_MULT, FN_MULTU, FN_DIV, FN_DIVU,
    FN_ADD, FN_ADDU, FN_SUB, FN_SUBU, FN_AND, FN_OR, FN_XOR, FN_NOR, FN_SLT, FN_SLTU};
  localparam logic [5:0] MEM_OPS [8] = '{OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU,
                                         OP_SB, OP_SH, OP_SW};

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_stall;
  logic [31:0] in_instruction_word = 0;
  logic        out_valid;
  logic        out_stall = 1;
  logic [31:0] out_next_pc;
  logic        out_reg_write_enable;
  logic [4:0]  out_reg_write_index;
  logic [31:0] out_reg_write_value;
  logic [31:0] out_hi_value;
  logic [31:0] out_lo_value;
  logic        out_halt;
  logic        out_syscall_seen;
  logic [31:0] out_syscall_code;
  logic [31:0] out_syscall_argument;
  logic        out_illegal;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [31:0] cfg_start_address = 0;
  int          fail_count, pending, checked;
  int          items_sent = 0;
  int          cycles = 0;

  mips_integer_core_step uut (.*);
  mips_integer_core_step_checker checker_i (.*);

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  // hard stop for a hung block
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("Regression FAIL");
      $finish;
    end
  end

  // receiver: random back-pressure, plus one long hold-off
  initial begin
    int n;
    bit held;
    held = 0;
    @(posedge clk);
    forever begin
      n = $urandom_range(0, 9);
      if (!held && checked >= 300) begin
        held = 1;
        n = 400;
      end
      if (n > 0) begin
        out_stall <= 1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  function automatic logic [31:0] enc_r(logic [4:0] rs, rt, rd, sh, logic [5:0] fn);
    return {OP_SPECIAL, rs, rt, rd, sh, fn};
  endfunction

  function automatic logic [31:0] enc_i(logic [5:0] op, logic [4:0] rs, rt,
                                        logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  // mostly low registers so values and memory addresses get reused
  function automatic logic [4:0] pick_reg();
    return ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, 7));
  endfunction

  function automatic logic [31:0] random_instruction();
    int r;
    logic [15:0] imm;
    r = $urandom_range(0, 99);
    imm = ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'($urandom_range(0, 64));
    if (r < 8) return $urandom;
    if (r < 16) return enc_i(6'($urandom_range(OP_ADDIU, OP_LUI)), pick_reg(), pick_reg(),
                             16'($urandom));
    if (r < 19) return enc_i(OP_ADDIU, 5'd0, 5'd2, ($urandom_range(0, 1) ? 16'd10 : 16'd9));
    if (r < 23) return enc_r(pick_reg(), pick_reg(), pick_reg(), 5'($urandom), FN_SYSCALL);
    if (r < 48) return enc_r(pick_reg(), pick_reg(), pick_reg(), 5'($urandom),
                             FN_LIST[$urandom_range(0, 26)]);
    if (r < 62) return enc_i(6'($urandom_range(OP_ADDI, OP_LUI)), pick_reg(), pick_reg(), imm);
    if (r < 80) return enc_i(MEM_OPS[$urandom_range(0, 7)], pick_reg(), pick_reg(), imm);
    if (r < 86) return enc_i(6'($urandom_range(OP_BEQ, OP_BGTZ)), pick_reg(), pick_reg(),
                             16'($urandom));
    if (r < 90) return enc_i(OP_REGIMM, pick_reg(),
                             ($urandom_range(0, 5) == 0) ? 5'($urandom) : 5'($urandom_range(0, 1)),
                             16'($urandom));
    if (r < 94) return {($urandom_range(0, 1) ? OP_JAL : OP_J), 26'($urandom)};
    return enc_r(pick_reg(), 5'($urandom), 5'($urandom), 5'($urandom),
                 $urandom_range(0, 1) ? FN_JALR : FN_JR);
  endfunction

  task automatic send_item(logic [31:0] iw);
    int gap;
    gap = $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_instruction_word <= iw;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // load start address only with the block drained
  task automatic set_start_address(logic [31:0] addr);
    in_valid <= 0;
    @(posedge clk);
    wait (pending == 0);
    repeat (40) @(posedge clk);
    cfg_valid <= 1;
    cfg_start_address <= addr;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
  endtask

  initial begin
    logic [31:0] directed [$];
    logic [31:0] starts [4];
    repeat (2) @(posedge clk);
    rst_n <= 1;

    starts = '{32'h0000_0000, 32'hffff_ffff, $urandom, 32'h0fff_fffc};
    set_start_address(starts[0]);

    // directed: extremes, div corner cases, register zero, jalr link, syscalls
    directed = {
      enc_i(OP_ADDIU, 5'd0, 5'd1, 16'hffff),
      enc_i(OP_LUI, 5'd0, 5'd3, 16'h8000),
      enc_r(5'd3, 5'd1, 5'd0, 5'd0, FN_DIV),
      enc_r(5'd3, 5'd0, 5'd0, 5'd0, FN_DIVU),
      enc_r(5'd1, 5'd0, 5'd0, 5'd0, FN_DIV),
      enc_r(5'd3, 5'd1, 5'd0, 5'd0, FN_MULT),
      enc_r(5'd1, 5'd1, 5'd0, 5'd0, FN_MULTU),
      enc_r(5'd0, 5'd0, 5'd5, 5'd0, FN_MFHI),
      enc_r(5'd0, 5'd0, 5'd6, 5'd0, FN_MFLO),
      enc_r(5'd1, 5'd3, 5'd7, 5'd0, FN_SRAV),
      enc_r(5'd0, 5'd3, 5'd7, 5'd31, FN_SRA),
      enc_r(5'd3, 5'd1, 5'd0, 5'd0, FN_ADD),
      enc_r(5'd3, 5'd1, 5'd8, 5'd0, FN_ADD),
      enc_i(OP_SW, 5'd0, 5'd3, 16'h0003),
      enc_i(OP_LW, 5'd0, 5'd9, 16'h0002),
      enc_i(OP_LH, 5'd0, 5'd10, 16'h0005),
      enc_i(OP_LB, 5'd0, 5'd10, 16'h0006),
      enc_i(OP_ADDIU, 5'd0, 5'd31, 16'h0040),
      enc_r(5'd31, 5'd0, 5'd31, 5'd0, FN_JALR),
      enc_i(OP_ADDIU, 5'd0, 5'd2, 16'd10),
      enc_r(5'd0, 5'd0, 5'd0, 5'd0, FN_SYSCALL),
      enc_i(OP_ADDIU, 5'd0, 5'd2, 16'd9),
      enc_r(5'd0, 5'd0, 5'd0, 5'd0, FN_SYSCALL),
      enc_i(OP_BEQ, 5'd0, 5'd0, 16'h8000),
      {OP_JAL, 26'h3ff_ffff},
      enc_i(OP_REGIMM, 5'd1, 5'd2, 16'h0004),
      enc_r(5'd0, 5'd0, 5'd0, 5'd0, 6'd1),
      32'hffff_ffff
    };
    foreach (directed[i]) send_item(directed[i]);

    for (int ph = 0; ph < 4; ph++) begin
      if (ph > 0) set_start_address(starts[ph]);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // sender pause until everything is back
        if (ph == 1 && i == 200) begin
          in_valid <= 0;
          @(posedge clk);
          wait (pending == 0);
          @(posedge clk);
        end
        send_item(random_instruction());
      end
    end
    in_valid <= 0;
    @(posedge clk);

    wait (pending == 0);
    repeat (60) @(posedge clk);
    $display("sent %0d instruction items over 4 start addresses, %0d results compared",
             items_sent, checked);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
